@@ design/bweg_pkg.sv @@
// Shared types and constants for the exp-Golomb bitstream writer.
`default_nettype none

package bweg_pkg;

    // Accumulator word width in bits.
    localparam int WORD_BITS = 32;
    // Command queue depth and its pointer width.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;
    // Largest unsigned exp-Golomb value before saturation.
    localparam logic [15:0] UE_MAX = 16'hFFFE;

    // Command codes on the input channel.
    typedef enum logic [2:0] {
        FUNC_BITS  = 3'd0,
        FUNC_BIT   = 3'd1,
        FUNC_UE    = 3'd2,
        FUNC_SE    = 3'd3,
        FUNC_FLUSH = 3'd4
    } t_func;

    // Kind of work that the back end carries out.
    typedef enum logic {
        KIND_APPEND = 1'b0,
        KIND_FLUSH  = 1'b1
    } t_kind;

    // One queued command: a masked value and its bit length, or a flush.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic [5:0]  len;
    } t_entry;

endpackage

`default_nettype wire

@@ design/bweg_front.sv @@
// Command classifier: turns an input word into an append or flush entry.
`default_nettype none

module bweg_front (
    input  wire logic [2:0]        i_func,
    input  wire logic [31:0]       i_unsigned_value,
    input  wire logic [15:0]       i_signed_value,
    input  wire logic [5:0]        i_bit_count,
    output bweg_pkg::t_entry       o_entry,
    output logic                   o_keep
);

    logic [16:0] s_ext;
    logic [16:0] s_neg;
    logic [16:0] mapped;
    logic [31:0] ue_in;
    logic [15:0] ue_sat;
    logic [15:0] code;
    logic [3:0]  lz;
    logic [5:0]  cnt_clip;
    logic [31:0] bit_mask;

    // Signed to unsigned mapping: zero and negatives go to even codes.
    assign s_ext = {i_signed_value[15], i_signed_value};
    assign s_neg = 17'd0 - s_ext;
    always_comb begin
        if (i_signed_value[15] || (i_signed_value == 16'd0)) begin
            mapped = {s_neg[15:0], 1'b0};
        end else begin
            mapped = {s_ext[15:0], 1'b0} - 17'd1;
        end
    end

    // Pick the exp-Golomb source and saturate it.
    assign ue_in = (bweg_pkg::t_func'(i_func) == bweg_pkg::FUNC_SE)
                   ? {15'd0, mapped} : i_unsigned_value;
    assign ue_sat = (ue_in > {16'd0, bweg_pkg::UE_MAX}) ? bweg_pkg::UE_MAX : ue_in[15:0];
    assign code = ue_sat + 16'd1;

    // Position of the highest set bit of the code.
    always_comb begin
        lz = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (code[i]) begin
                lz = 4'(i);
            end
        end
    end

    // Bit count clipped to a word, and the mask of the bits kept.
    assign cnt_clip = (i_bit_count > 6'd32) ? 6'd32 : i_bit_count;
    assign bit_mask = 32'((33'd1 << cnt_clip) - 33'd1);

    // Build the queue entry for each command.
    always_comb begin
        o_entry.kind  = bweg_pkg::KIND_APPEND;
        o_entry.value = 32'd0;
        o_entry.len   = 6'd0;
        o_keep        = 1'b0;
        unique case (bweg_pkg::t_func'(i_func))
            bweg_pkg::FUNC_BITS: begin
                o_entry.value = i_unsigned_value & bit_mask;
                o_entry.len   = cnt_clip;
                o_keep        = (cnt_clip != 6'd0);
            end
            bweg_pkg::FUNC_BIT: begin
                o_entry.value = {31'd0, i_unsigned_value[0]};
                o_entry.len   = 6'd1;
                o_keep        = 1'b1;
            end
            bweg_pkg::FUNC_UE, bweg_pkg::FUNC_SE: begin
                o_entry.value = {16'd0, code};
                o_entry.len   = {1'b0, lz, 1'b1};
                o_keep        = 1'b1;
            end
            bweg_pkg::FUNC_FLUSH: begin
                o_entry.kind = bweg_pkg::KIND_FLUSH;
                o_keep       = 1'b1;
            end
            default: begin
                o_keep = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/bweg_queue.sv @@
// Short command queue between the classifier and the packer.
`default_nettype none

module bweg_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  bweg_pkg::t_entry       i_entry,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_pop,
    output bweg_pkg::t_entry       o_entry
);

    bweg_pkg::t_entry r_mem [bweg_pkg::QUEUE_DEPTH];
    logic [bweg_pkg::QUEUE_AW-1:0] r_wr;
    logic [bweg_pkg::QUEUE_AW-1:0] r_rd;
    logic [bweg_pkg::QUEUE_AW:0]   r_cnt;
    logic [bweg_pkg::QUEUE_AW:0]   n_cnt;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_cnt == (bweg_pkg::QUEUE_AW + 1)'(bweg_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Occupancy follows pushes and pops.
    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

@@ design/bweg_back.sv @@
// Bit packer: merges entries into the accumulator and sends out finished bytes.
`default_nettype none

module bweg_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  bweg_pkg::t_entry       i_q_entry,
    output logic                   o_q_pop,
    output logic [7:0]             o_out_byte,
    output logic                   o_last_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready
);

    logic [31:0] r_acc;
    logic [31:0] n_acc;
    logic [4:0]  r_used;
    logic [4:0]  n_used;
    logic [31:0] r_emit;
    logic [31:0] n_emit;
    logic [2:0]  r_emit_cnt;
    logic [2:0]  n_emit_cnt;
    logic        emit_free;
    logic        out_take;
    logic [5:0]  total;
    logic [63:0] merged;
    logic [5:0]  used_up;
    logic [2:0]  flush_bytes;

    assign out_take    = o_out_valid && i_out_ready;
    assign o_out_valid = (r_emit_cnt != 3'd0);
    assign o_out_byte  = r_emit[31:24];
    assign o_last_byte = (r_emit_cnt == 3'd1);

    // The byte register is free once its last byte leaves.
    assign emit_free = (r_emit_cnt == 3'd0) || ((r_emit_cnt == 3'd1) && i_out_ready);
    assign o_q_pop   = i_q_valid && emit_free;

    // New bits land right after the used ones in a two-word window.
    assign total  = {1'b0, r_used} + i_q_entry.len;
    assign merged = {r_acc, 32'd0} | ({32'd0, i_q_entry.value} << (7'd64 - {1'b0, total}));

    // Whole bytes holding used bits, for a flush.
    assign used_up     = {1'b0, r_used} + 6'd7;
    assign flush_bytes = used_up[5:3];

    // Accumulator and byte register updates.
    always_comb begin
        n_acc      = r_acc;
        n_used     = r_used;
        n_emit     = r_emit;
        n_emit_cnt = r_emit_cnt;
        if (out_take) begin
            n_emit     = {r_emit[23:0], 8'd0};
            n_emit_cnt = r_emit_cnt - 3'd1;
        end
        if (o_q_pop) begin
            unique case (i_q_entry.kind)
                bweg_pkg::KIND_APPEND: begin
                    if (total[5]) begin
                        n_emit     = merged[63:32];
                        n_emit_cnt = 3'd4;
                        n_acc      = merged[31:0];
                        n_used     = total[4:0];
                    end else begin
                        n_acc  = merged[63:32];
                        n_used = total[4:0];
                    end
                end
                bweg_pkg::KIND_FLUSH: begin
                    if (flush_bytes != 3'd0) begin
                        n_emit     = r_acc;
                        n_emit_cnt = flush_bytes;
                    end
                    n_acc  = 32'd0;
                    n_used = 5'd0;
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    // Control state and accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= 32'd0;
            r_used     <= 5'd0;
            r_emit_cnt <= 3'd0;
        end else begin
            r_acc      <= n_acc;
            r_used     <= n_used;
            r_emit_cnt <= n_emit_cnt;
        end
    end

    // Outgoing bytes.
    always_ff @(posedge i_clk) begin
        r_emit <= n_emit;
    end

`ifndef ASSERT_OFF
    // The byte register never holds more than one word.
    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_cnt <= 3'd4)
        else $error("byte count above four");

    // A flush leaves the accumulator empty.
    a_flush_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && (i_q_entry.kind == bweg_pkg::KIND_FLUSH))
        |=> ((r_used == 5'd0) && (r_acc == 32'd0)))
        else $error("flush did not clear the accumulator");

    // An entry is never taken while undelivered bytes would be overwritten.
    a_pop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> ((r_emit_cnt == 3'd0) || ((r_emit_cnt == 3'd1) && out_take)))
        else $error("entry taken over pending bytes");
`endif

endmodule

`default_nettype wire

@@ design/bitstream_writer_exp_golomb_unit.sv @@
// Exp-Golomb bitstream writer: a command word goes in, stream bytes come out MSB first.
// With an empty queue, a command that completes a word or flushes is written into the queue,
// then taken into the byte register, from which its first byte is presented.
// One command per cycle enters a four-entry queue while it has room; the packer retires one
// command per cycle while its byte register is free, and a command that completes a word or
// flushes holds it while its bytes leave at one byte per cycle as long as the output is ready.
// Reset (synchronous, active low) empties the queue, the accumulator and the byte register.
`default_nettype none

module bitstream_writer_exp_golomb_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_func,
    input  wire logic [31:0] i_unsigned_value,
    input  wire logic [15:0] i_signed_value,
    input  wire logic [5:0]  i_bit_count,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last_byte
);

    bweg_pkg::t_entry front_entry;
    bweg_pkg::t_entry q_entry;
    logic             front_keep;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;

    assign o_in_ready = !q_full;

    // Classify each accepted word.
    bweg_front u_front (
        .i_func           (i_func),
        .i_unsigned_value (i_unsigned_value),
        .i_signed_value   (i_signed_value),
        .i_bit_count      (i_bit_count),
        .o_entry          (front_entry),
        .o_keep           (front_keep)
    );

    // Decouple classification from packing.
    bweg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && front_keep),
        .i_entry (front_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_entry (q_entry)
    );

    // Pack bits and deliver bytes.
    bweg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule

`default_nettype wire
